### sv/qse_pkg.sv
// Package with shared types, constants and the byte escape function.
package qse_pkg;

  // Character codes used by the escaper.
  localparam logic [7:0] QSE_CH_QUOTE     = 8'h22;
  localparam logic [7:0] QSE_CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] QSE_CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] QSE_CH_ZERO      = 8'h30;
  localparam logic [7:0] QSE_CH_NINE      = 8'h39;
  localparam logic [7:0] QSE_CH_DELETE    = 8'd127;
  localparam logic [7:0] QSE_CTRL_LIMIT   = 8'd32;
  localparam logic [7:0] QSE_HUNDRED      = 8'd100;
  localparam logic [7:0] QSE_TEN          = 8'd10;

  // Divide by ten through multiplication by a scaled reciprocal.
  localparam logic [15:0] QSE_RECIP_TEN = 16'd205;
  localparam int          QSE_RECIP_SHIFT = 11;

  // Default depth of the queue between front and back.
  localparam int QSE_QUEUE_DEPTH = 4;

  // Input request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       empty_string;
  } qse_in_req_t;

  // Output request.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
  } qse_out_req_t;

  // Escape sequence of one byte: up to four characters.
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] ch;
  } qse_esc_t;

  // Command handed from front to back: quote, two escapes, quote.
  typedef struct packed {
    logic     open_q;
    qse_esc_t seq_a;
    qse_esc_t seq_b;
    logic     close_q;
  } qse_cmd_t;

  function automatic logic qse_is_digit(input logic [7:0] v);
    return (v >= QSE_CH_ZERO) && (v <= QSE_CH_NINE);
  endfunction

  // Build the escaped character sequence of one byte.
  function automatic qse_esc_t qse_escape(input logic [7:0] c, input logic next_digit);
    qse_esc_t    e;
    logic        big;
    logic [7:0]  v;
    logic [15:0] prod;
    logic [7:0]  d;
    logic [7:0]  r;
    big  = (c >= QSE_HUNDRED);
    v    = big ? (c - QSE_HUNDRED) : c;
    prod = {8'b0, v} * QSE_RECIP_TEN;
    d    = 8'(prod >> QSE_RECIP_SHIFT);
    r    = v - 8'(d * QSE_TEN);
    e.ch    = '0;
    e.len   = 3'd1;
    e.ch[0] = c;
    if ((c == QSE_CH_QUOTE) || (c == QSE_CH_BACKSLASH) || (c == QSE_CH_NEWLINE)) begin
      e.len   = 3'd2;
      e.ch[0] = QSE_CH_BACKSLASH;
      e.ch[1] = c;
    end else if ((c < QSE_CTRL_LIMIT) || (c == QSE_CH_DELETE)) begin
      e.ch[0] = QSE_CH_BACKSLASH;
      if (big || next_digit) begin
        e.len   = 3'd4;
        e.ch[1] = QSE_CH_ZERO + {7'b0, big};
        e.ch[2] = QSE_CH_ZERO + d;
        e.ch[3] = QSE_CH_ZERO + r;
      end else if (v >= QSE_TEN) begin
        e.len   = 3'd3;
        e.ch[1] = QSE_CH_ZERO + d;
        e.ch[2] = QSE_CH_ZERO + r;
      end else begin
        e.len   = 3'd2;
        e.ch[1] = QSE_CH_ZERO + r;
      end
    end
    return e;
  endfunction

endpackage

### sv/qse_front.sv
// Front part: accepts input requests, keeps the lookahead byte, builds commands.
module qse_front
  import qse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  qse_in_req_t in_req,
  input  logic        q_full,
  output logic        q_push,
  output qse_cmd_t    q_cmd
);

  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       accept;

  // Stall only when the queue has no room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // Classify the request and work out the next lookahead state.
  always_comb begin
    q_cmd          = '0;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    if (in_req.empty_string) begin
      q_cmd.open_q   = 1'b1;
      q_cmd.close_q  = 1'b1;
      held_byte_nxt  = '0;
      held_valid_nxt = 1'b0;
    end else begin
      if (in_req.first_byte || !held_valid_r) begin
        q_cmd.open_q = 1'b1;
      end else begin
        q_cmd.seq_a = qse_escape(held_byte_r, qse_is_digit(in_req.data_byte));
      end
      if (in_req.last_byte) begin
        q_cmd.seq_b    = qse_escape(in_req.data_byte, 1'b0);
        q_cmd.close_q  = 1'b1;
        held_byte_nxt  = '0;
        held_valid_nxt = 1'b0;
      end else begin
        held_byte_nxt  = in_req.data_byte;
        held_valid_nxt = 1'b1;
      end
    end
  end

  // Lookahead registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_byte_r  <= '0;
    end else if (accept) begin
      held_valid_r <= held_valid_nxt;
      held_byte_r  <= held_byte_nxt;
    end
  end

endmodule

### sv/qse_queue.sv
// Short command queue between the front and the back part.
module qse_queue
  import qse_pkg::*;
#(
  parameter int DEPTH = QSE_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  qse_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output qse_cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  qse_cmd_t      mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  // Pointer and fill count updates, with wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### sv/qse_back.sv
// Back part: walks a command one output byte per cycle, while the output is not stalled, into the output register.
module qse_back
  import qse_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  qse_cmd_t     q_head,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output qse_out_req_t out_req
);

  logic         out_valid_r, out_valid_nxt;
  qse_out_req_t out_req_r, out_req_nxt;
  logic [3:0]   idx_r, idx_nxt;
  logic [3:0]   off_a, off_b, off_c, total;
  logic [3:0]   sel_a, sel_b;
  logic         last_pos;
  logic         advance;
  logic [7:0]   cur_byte;

  // Segment boundaries inside the command.
  assign off_a    = {3'b0, q_head.open_q};
  assign off_b    = off_a + {1'b0, q_head.seq_a.len};
  assign off_c    = off_b + {1'b0, q_head.seq_b.len};
  assign total    = off_c + {3'b0, q_head.close_q};
  assign sel_a    = idx_r - off_a;
  assign sel_b    = idx_r - off_b;
  assign last_pos = (idx_r == (total - 4'd1));
  assign advance  = !out_valid_r || !out_stall;
  assign q_pop    = advance && !q_empty && last_pos;

  // Pick the character at the current position.
  always_comb begin
    if (idx_r < off_a) begin
      cur_byte = QSE_CH_QUOTE;
    end else if (idx_r < off_b) begin
      cur_byte = q_head.seq_a.ch[sel_a[1:0]];
    end else if (idx_r < off_c) begin
      cur_byte = q_head.seq_b.ch[sel_b[1:0]];
    end else begin
      cur_byte = QSE_CH_QUOTE;
    end
  end

  // Next output register contents and position.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_req_nxt   = out_req_r;
    idx_nxt       = idx_r;
    if (advance) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        out_req_nxt.out_byte   = cur_byte;
        out_req_nxt.run_end    = last_pos;
        out_req_nxt.string_end = (idx_r >= off_c);
        idx_nxt                = last_pos ? 4'd0 : idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_req_r <= out_req_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

### sv/quoted_string_escaper.sv
// Top level: an accepted request is written into the command queue, and its first output byte is then
// registered in the output register of the back part. Output rate is one byte per cycle while the output
// is not stalled, set by the single output register of the back part; a request yields 1 to 9 output bytes.
// Requests are taken back to back while the command queue has room.
// Synchronous active-low reset empties the queue, drops the lookahead byte and the output.
module quoted_string_escaper
  import qse_pkg::*;
#(
  parameter int QUEUE_DEPTH = QSE_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  qse_in_req_t  in_req,
  output logic         out_valid,
  input  logic         out_stall,
  output qse_out_req_t out_req
);

  logic     q_full, q_push, q_pop, q_empty;
  qse_cmd_t q_cmd, q_head;

  // Front: lookahead and classification.
  qse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // Queue between the two parts.
  qse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back: byte emission.
  qse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

endmodule

### tb/escape_checker.sv
// Checker that predicts the escaped character stream and compares it with the block's output.
module escape_checker
  import qse_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_stall,
  input  qse_in_req_t  in_req,
  input  logic         out_valid,
  input  logic         out_stall,
  input  qse_out_req_t out_req,
  output int           failures,
  output int           pending,
  output int           requests_seen,
  output int           chars_seen,
  output int           strings_closed,
  output int           numeric_escapes
);
  timeunit 1ns;
  timeprecision 1ps;

  // Lookahead state of the predicted escaper.
  logic [7:0]   lookahead_char;
  logic         lookahead_held;
  qse_out_req_t expected_chars[$];
  qse_out_req_t want;

  // Append one predicted character; run_end is fixed up once the whole request is expanded.
  task automatic push_char(input logic [7:0] ch, input logic closing);
    qse_out_req_t r;
    r.out_byte   = ch;
    r.run_end    = 1'b0;
    r.string_end = closing;
    expected_chars.push_back(r);
  endtask

  // Escaped form of one string byte, given whether a digit follows it.
  task automatic escape_char(input logic [7:0] c, input logic digit_follows);
    int n;
    n = int'(c);
    if (c == QSE_CH_QUOTE || c == QSE_CH_BACKSLASH || c == QSE_CH_NEWLINE) begin
      push_char(QSE_CH_BACKSLASH, 1'b0);
      push_char(c, 1'b0);
    end else if (c < QSE_CTRL_LIMIT || c == QSE_CH_DELETE) begin
      numeric_escapes++;
      push_char(QSE_CH_BACKSLASH, 1'b0);
      if (c >= QSE_HUNDRED || digit_follows) begin
        // Fixed three-digit form so a following digit cannot be absorbed.
        push_char(8'(int'(QSE_CH_ZERO) + n / 100), 1'b0);
        push_char(8'(int'(QSE_CH_ZERO) + (n / 10) % 10), 1'b0);
        push_char(8'(int'(QSE_CH_ZERO) + n % 10), 1'b0);
      end else if (c >= QSE_TEN) begin
        push_char(8'(int'(QSE_CH_ZERO) + n / 10), 1'b0);
        push_char(8'(int'(QSE_CH_ZERO) + n % 10), 1'b0);
      end else begin
        push_char(8'(int'(QSE_CH_ZERO) + n), 1'b0);
      end
    end else begin
      push_char(c, 1'b0);
    end
  endtask

  // Expand one accepted request into the characters it must produce.
  task automatic expand_request(input qse_in_req_t r);
    logic is_digit;
    is_digit = (r.data_byte >= QSE_CH_ZERO) && (r.data_byte <= QSE_CH_NINE);
    if (r.empty_string) begin
      // A zero-length string drops any pending byte and emits a bare pair of quotes.
      lookahead_held = 1'b0;
      lookahead_char = '0;
      push_char(QSE_CH_QUOTE, 1'b0);
      push_char(QSE_CH_QUOTE, 1'b1);
    end else begin
      if (r.first_byte || !lookahead_held) begin
        // New string: an unfinished one is abandoned without a closing quote.
        lookahead_held = 1'b0;
        push_char(QSE_CH_QUOTE, 1'b0);
      end else begin
        escape_char(lookahead_char, is_digit);
      end
      if (r.last_byte) begin
        escape_char(r.data_byte, 1'b0);
        push_char(QSE_CH_QUOTE, 1'b1);
        lookahead_held = 1'b0;
        lookahead_char = '0;
      end else begin
        lookahead_char = r.data_byte;
        lookahead_held = 1'b1;
      end
    end
    expected_chars[expected_chars.size() - 1].run_end = 1'b1;
  endtask

  // Watch both channels; requests are expanded before outputs are compared.
  always @(posedge clk) begin
    if (!rst_n) begin
      lookahead_char  = '0;
      lookahead_held  = 1'b0;
      expected_chars.delete();
      failures        = 0;
      requests_seen   = 0;
      chars_seen      = 0;
      strings_closed  = 0;
      numeric_escapes = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expand_request(in_req);
        requests_seen++;
      end
      if (out_valid && !out_stall) begin
        chars_seen++;
        if (out_req.string_end) strings_closed++;
        if (expected_chars.size() == 0) begin
          $error("out_req: no character expected, got out_byte %h run_end %b string_end %b",
                 out_req.out_byte, out_req.run_end, out_req.string_end);
          failures++;
        end else begin
          want = expected_chars.pop_front();
          if (out_req.out_byte !== want.out_byte) begin
            $error("out_byte mismatch: expected %h, got %h", want.out_byte, out_req.out_byte);
            failures++;
          end
          if (out_req.run_end !== want.run_end) begin
            $error("run_end mismatch: expected %b, got %b", want.run_end, out_req.run_end);
            failures++;
          end
          if (out_req.string_end !== want.string_end) begin
            $error("string_end mismatch: expected %b, got %b",
                   want.string_end, out_req.string_end);
            failures++;
          end
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

### tb/testbench.sv
// Top of the escaper testbench: clock, reset, request stimulus, output stalls and verdict.
module testbench;
  import qse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STREAM_ITEMS    = 410;
  localparam int HOLD_OFF_AFTER  = 150;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 1500;
  localparam int DRAIN_CYCLES    = 16;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  qse_in_req_t  in_req = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  qse_out_req_t out_req;

  int failures;
  int pending;
  int requests_seen;
  int chars_seen;
  int strings_closed;
  int numeric_escapes;

  qse_in_req_t stream[$];
  int          sent_count = 0;
  bit          stimulus_done = 1'b0;
  int          idle_cycles = 0;

  quoted_string_escaper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  escape_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req          (in_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_req         (out_req),
    .failures        (failures),
    .pending         (pending),
    .requests_seen   (requests_seen),
    .chars_seen      (chars_seen),
    .strings_closed  (strings_closed),
    .numeric_escapes (numeric_escapes)
  );

  always #6 clk = ~clk;

  // Reset is held at the start and then released for the rest of the run.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic add_req(input logic [7:0] ch, input logic opens, input logic closes,
                         input logic is_empty);
    qse_in_req_t r;
    r.data_byte    = ch;
    r.first_byte   = opens;
    r.last_byte    = closes;
    r.empty_string = is_empty;
    stream.push_back(r);
  endtask

  task automatic add_single(input logic [7:0] ch);
    add_req(ch, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic add_pair(input logic [7:0] a, input logic [7:0] b);
    add_req(a, 1'b1, 1'b0, 1'b0);
    add_req(b, 1'b0, 1'b1, 1'b0);
  endtask

  // String bytes weighted toward the characters that need escaping.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range(0, 31));
      1: return 8'($urandom_range(QSE_CH_ZERO, QSE_CH_NINE));
      2: begin
        case ($urandom_range(0, 3))
          0: return QSE_CH_QUOTE;
          1: return QSE_CH_BACKSLASH;
          2: return QSE_CH_NEWLINE;
          default: return QSE_CH_DELETE;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A string of random bytes; an unclosed one is left for the next start to abandon.
  task automatic add_string(input int len, input bit closed);
    for (int k = 0; k < len; k++) begin
      add_req(pick_char(), k == 0, closed && (k == len - 1), 1'b0);
    end
  endtask

  task automatic build_stream();
    int pick;
    // Byte with no string open, then a closing control byte.
    add_req(8'h41, 1'b0, 1'b0, 1'b0);
    add_req(8'h00, 1'b0, 1'b1, 1'b0);
    // One-byte strings at the edges of each escape class.
    add_single(8'h00);
    add_single(8'h09);
    add_single(QSE_CH_NEWLINE);
    add_single(8'h1F);
    add_single(QSE_CH_DELETE);
    add_single(QSE_CH_QUOTE);
    add_single(QSE_CH_BACKSLASH);
    add_single(8'hFF);
    add_single(8'h80);
    // Control bytes followed by a digit and by the neighbors of the digit range.
    add_pair(8'h01, QSE_CH_ZERO);
    add_pair(8'h1F, QSE_CH_NINE);
    add_pair(QSE_CH_DELETE, 8'h35);
    add_pair(8'h0C, 8'h3A);
    add_pair(8'h0D, 8'h2F);
    // Empty string with the other flags set.
    add_req(8'hFF, 1'b1, 1'b1, 1'b1);
    // A start that abandons an open string, then an empty string that drops the held byte.
    add_req(8'h78, 1'b1, 1'b0, 1'b0);
    add_req(8'h79, 1'b1, 1'b0, 1'b0);
    add_req(8'h00, 1'b0, 1'b0, 1'b1);

    // Mostly well-formed strings, with empty strings, truncated strings and noise.
    while (stream.size() < STREAM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        add_req(8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
      end else if (pick < 85) begin
        add_string(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8),
                   1'b1);
      end else if (pick < 92) begin
        add_string($urandom_range(1, 6), 1'b0);
      end else begin
        add_req(8'($urandom), 1'($urandom), 1'($urandom), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // Sender: bursts of requests with random gaps between them.
  initial begin
    int  burst;
    int  gap;
    int  idx;
    bit  taken;
    build_stream();
    @(posedge clk iff rst_n);
    idx = 0;
    while (idx < stream.size()) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && idx < stream.size()) begin
        in_valid <= 1'b1;
        in_req   <= stream[idx];
        do begin
          @(negedge clk);
          taken = !in_stall;
          @(posedge clk);
        end while (!taken);
        idx++;
        sent_count++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver: stall patterns in spans, plus one long hold-off that backs up the block.
  initial begin
    int mode;
    int span;
    int tick;
    bit held_off;
    held_off = 1'b0;
    tick = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held_off && sent_count >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 80);
        repeat (span) begin
          tick++;
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= 1'($urandom);
            default: out_stall <= (tick % 7 < 2);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles, %0d characters still expected",
               idle_cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Verdict once every request is in and every expected character has come out.
  initial begin
    wait (stimulus_done);
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests and %0d output characters, %0d strings closed.",
             requests_seen, chars_seen, strings_closed);
    $display("%0d numeric escapes, with a %0d-cycle receiver hold-off along the way.",
             numeric_escapes, HOLD_OFF_CYCLES);
    if (failures == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
